@@ hw/rtl/rdc_pkg.sv @@
// Shared constants and types for the radix digit converter.
`default_nettype none

package rdc_pkg;

   localparam int RDC_VALUE_BITS     = 64;
   localparam int RDC_MAX_DIGITS     = 64;
   localparam int RDC_IN_BITS        = 64;
   localparam int RDC_DIGIT_BITS     = 6;
   localparam int RDC_RADIX_BITS     = 6;
   localparam int RDC_STEP_BITS      = 8;
   localparam int RDC_QUEUE_DEPTH    = 2;
   localparam int RDC_CSR_ADDR_BITS  = 3;
   localparam int RDC_CSR_DATA_BITS  = 32;

   localparam logic [RDC_RADIX_BITS-1:0] RDC_RADIX_RESET = 6'd10;
   localparam logic [RDC_RADIX_BITS-1:0] RDC_RADIX_MIN   = 6'd2;
   localparam logic [RDC_RADIX_BITS-1:0] RDC_RADIX_MAX   = 6'd36;

   // register index, taken from the word address bits of paddr
   localparam logic RDC_CSR_RADIX = 1'b0;

   typedef struct packed {
      logic                      start;
      logic [RDC_RADIX_BITS-1:0] base;
   } rdc_div_cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/radix_digit_converter.sv @@
// Top level of the radix digit converter.
//
//  channel | ports             | direction | moves
//  req     | req_valid/_stall  | in        | one value per transfer
//  rsp     | rsp_valid/_stall  | out       | one digit per transfer, MSD first
//  csr     | csr_p*            | in/out    | radix register at byte address 0
//
// Each digit comes from the shared divider (8 quotient bits a cycle while a division
// runs); the digits are then read back from the digit stack and presented, one per
// transfer, as rsp takes them.
// Reset is synchronous; no clearing pass, the digit stack holds no reset value.
// A two-entry queue keeps taking values while results are stalled, until it is full.
`default_nettype none

module radix_digit_converter #(
   parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS,
   parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rdc_pkg::RDC_CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [rdc_pkg::RDC_CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [rdc_pkg::RDC_CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                       csr_pready,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [rdc_pkg::RDC_IN_BITS-1:0]       req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [rdc_pkg::RDC_DIGIT_BITS-1:0]    rsp_digit,
   output logic                                       rsp_last_digit
);
   import rdc_pkg::*;

   localparam int ITEM_BITS = VALUE_BITS + RDC_RADIX_BITS;

   logic                      push;
   logic [ITEM_BITS-1:0]      push_data;
   logic                      full;
   logic                      pop;
   logic [ITEM_BITS-1:0]      head_data;
   logic                      empty;
   rdc_div_cmd_type           div_cmd;
   logic [VALUE_BITS-1:0]     dividend;
   logic                      div_done;
   logic [VALUE_BITS-1:0]     div_quot;
   logic [RDC_RADIX_BITS-1:0] div_rem;

   rdc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .push        (push),
      .push_data   (push_data),
      .full        (full)
   );

   rdc_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (RDC_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (empty)
   );

   rdc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_cmd   (div_cmd),
      .dividend  (dividend),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rdc_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .head_data      (head_data),
      .pop            (pop),
      .div_cmd        (div_cmd),
      .dividend       (dividend),
      .div_done       (div_done),
      .div_quot       (div_quot),
      .div_rem        (div_rem),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

`default_nettype wire

@@ hw/rtl/rdc_front.sv @@
// Front end: radix register, input transfer acceptance and item preparation.
`default_nettype none

module rdc_front #(
   parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rdc_pkg::RDC_CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [rdc_pkg::RDC_CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [rdc_pkg::RDC_CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                       csr_pready,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [rdc_pkg::RDC_IN_BITS-1:0]       req_value,
   output logic                                       push,
   output logic [VALUE_BITS+rdc_pkg::RDC_RADIX_BITS-1:0] push_data,
   input  wire logic                                  full
);
   import rdc_pkg::*;

   logic [RDC_RADIX_BITS-1:0] radix_ff;
   logic [RDC_RADIX_BITS-1:0] radix_in;
   logic [RDC_RADIX_BITS-1:0] radix_eff;
   logic                      csr_hit;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[RDC_CSR_ADDR_BITS-1] == RDC_CSR_RADIX);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radix_in = radix_ff;
      if (csr_wr && csr_hit) begin
         radix_in = csr_pwdata[RDC_RADIX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RDC_RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata[RDC_RADIX_BITS-1:0] = radix_ff;
      end
   end

   always_comb begin
      radix_eff = radix_ff;
      if (radix_ff < RDC_RADIX_MIN) begin
         radix_eff = RDC_RADIX_MIN;
      end else if (radix_ff > RDC_RADIX_MAX) begin
         radix_eff = RDC_RADIX_MAX;
      end
   end

   assign req_stall = full;
   assign push      = req_valid && !full;
   assign push_data = {radix_eff, req_value[VALUE_BITS-1:0]};

endmodule

`default_nettype wire

@@ hw/rtl/rdc_queue.sv @@
// Small FIFO between the front end and the conversion engine.
`default_nettype none

module rdc_queue #(
   parameter int WIDTH = rdc_pkg::RDC_VALUE_BITS + rdc_pkg::RDC_RADIX_BITS,
   parameter int DEPTH = rdc_pkg::RDC_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  empty
);
   import rdc_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rdc_divider.sv @@
// Iterative divider by a small base, several quotient bits per cycle.
`default_nettype none

module rdc_divider #(
   parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rdc_pkg::rdc_div_cmd_type         div_cmd,
   input  wire logic [VALUE_BITS-1:0]            dividend,
   output logic                                  done,
   output logic      [VALUE_BITS-1:0]            quotient,
   output logic      [rdc_pkg::RDC_RADIX_BITS-1:0] remainder
);
   import rdc_pkg::*;

   localparam int STEPS     = (VALUE_BITS + RDC_STEP_BITS - 1) / RDC_STEP_BITS;
   localparam int PAD_BITS  = STEPS * RDC_STEP_BITS;
   localparam int STEP_CNT  = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [PAD_BITS-1:0]       quot_ff;
   logic [PAD_BITS-1:0]       quot_in;
   logic [RDC_RADIX_BITS-1:0] rem_ff;
   logic [RDC_RADIX_BITS-1:0] rem_in;
   logic [RDC_RADIX_BITS-1:0] base_ff;
   logic [RDC_RADIX_BITS-1:0] base_in;
   logic [STEP_CNT-1:0]       step_ff;
   logic [STEP_CNT-1:0]       step_in;
   logic                      busy_ff;
   logic                      busy_in;
   logic                      done_ff;
   logic                      done_in;
   logic [PAD_BITS-1:0]       q_work;
   logic [RDC_RADIX_BITS:0]   r_work;
   logic [RDC_RADIX_BITS-1:0] r_part;

   // restoring division, dividend shifts out at the top as quotient bits enter
   always_comb begin
      q_work = quot_ff;
      r_part = rem_ff;
      r_work = '0;
      for (int i = 0; i < RDC_STEP_BITS; i++) begin
         r_work = {r_part, q_work[PAD_BITS-1]};
         q_work = {q_work[PAD_BITS-2:0], 1'b0};
         if (r_work >= {1'b0, base_ff}) begin
            r_work    = r_work - {1'b0, base_ff};
            q_work[0] = 1'b1;
         end
         r_part = r_work[RDC_RADIX_BITS-1:0];
      end
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      base_in = base_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quot_in = q_work;
         rem_in  = r_part;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_cmd.start) begin
         quot_in = PAD_BITS'(dividend);
         rem_in  = '0;
         base_in = div_cmd.base;
         step_in = STEP_CNT'(STEPS - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rdc_back.sv @@
// Conversion engine: digit loop over the divider, digit stack and result output.
`default_nettype none

module rdc_back #(
   parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS,
   parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  empty,
   input  wire logic [VALUE_BITS+rdc_pkg::RDC_RADIX_BITS-1:0] head_data,
   output logic                                       pop,
   output rdc_pkg::rdc_div_cmd_type                   div_cmd,
   output logic      [VALUE_BITS-1:0]                 dividend,
   input  wire logic                                  div_done,
   input  wire logic [VALUE_BITS-1:0]                 div_quot,
   input  wire logic [rdc_pkg::RDC_RADIX_BITS-1:0]    div_rem,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [rdc_pkg::RDC_DIGIT_BITS-1:0]    rsp_digit,
   output logic                                       rsp_last_digit
);
   import rdc_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int IDX_BITS = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_RD,
      S_LD,
      S_OUT
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [VALUE_BITS-1:0]     q_ff;
   logic [VALUE_BITS-1:0]     q_in;
   logic [RDC_RADIX_BITS-1:0] base_ff;
   logic [RDC_RADIX_BITS-1:0] base_in;
   logic [CNT_BITS-1:0]       cnt_ff;
   logic [CNT_BITS-1:0]       cnt_in;
   logic [CNT_BITS-1:0]       cnt_inc;
   logic [IDX_BITS-1:0]       idx_ff;
   logic [IDX_BITS-1:0]       idx_in;
   logic                      start_ff;
   logic                      start_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RDC_DIGIT_BITS-1:0] digit_ff;
   logic [RDC_DIGIT_BITS-1:0] digit_in;
   logic                      last_ff;
   logic                      last_in;
   logic                      wr_en;
   logic [RDC_DIGIT_BITS-1:0] stack_ff [MAX_DIGITS];
   logic [RDC_DIGIT_BITS-1:0] rd_data_ff;

   assign cnt_inc = cnt_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      digit_in     = digit_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               q_in     = head_data[VALUE_BITS-1:0];
               base_in  = head_data[VALUE_BITS +: RDC_RADIX_BITS];
               cnt_in   = '0;
               start_in = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               wr_en  = 1'b1;
               q_in   = div_quot;
               cnt_in = cnt_inc;
               if ((div_quot != '0) && (cnt_inc < CNT_BITS'(MAX_DIGITS))) begin
                  start_in = 1'b1;
               end else begin
                  idx_in   = cnt_ff[IDX_BITS-1:0];
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            digit_in     = rd_data_ff;
            last_in      = (idx_ff == '0);
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff     <= q_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
   end

   // digit stack
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[cnt_ff[IDX_BITS-1:0]] <= div_rem;
      end
      rd_data_ff <= stack_ff[idx_ff];
   end

   assign div_cmd.start  = start_ff;
   assign div_cmd.base   = base_ff;
   assign dividend       = q_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = digit_ff;
   assign rsp_last_digit = last_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the division phase");

   a_start_in_div: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == S_DIV))
      else $error("divider started outside the division phase");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_digit) |=> (state_ff == S_IDLE))
      else $error("engine not idle after the final digit transfer");

   a_digits_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> ((cnt_ff != '0) && (cnt_ff <= CNT_BITS'(MAX_DIGITS))))
      else $error("digit read with no digits stacked");

endmodule

`default_nettype wire
